// File: hw/rtl/xatp_pkg.sv
// ----------------------------------------------------------------------------
// xatp_pkg
// Shared types and constants for the XOR archive table parser.
// ----------------------------------------------------------------------------
package xatp_pkg;

  // Result kinds carried in the kind field of an output word.
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [7:0]  KEY_RESET    = 8'hF7;
  localparam int unsigned END_FLAG_BIT = 7;
  localparam logic [3:0]  TAIL_LAST    = 4'd11;   // twelfth tail byte
  localparam logic [15:0] INDEX_MAX    = 16'hFFFF;
  localparam logic [31:0] HEADER_BYTES = 32'd8;
  localparam logic [7:0]  CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0]  CHAR_SLASH   = 8'h2F;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       restart;
  } xatp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] entry_index;
    logic [31:0] entry_size;
    logic [31:0] data_position;
  } xatp_out_t;

  // Handshake between the input stage and the rest of the pipe.
  typedef struct packed {
    logic valid;  // input stage holds a word
    logic drain;  // that word is consumed at this edge
  } xatp_flow_t;

endpackage

// File: hw/rtl/xatp_input_stage.sv
// ----------------------------------------------------------------------------
// xatp_input_stage
// Input register that captures one raw table byte per accepted word.
// ----------------------------------------------------------------------------
module xatp_input_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  xatp_pkg::xatp_in_t in_data_i,
  input  logic              drain_i,
  output logic              valid_o,
  output xatp_pkg::xatp_in_t data_o
);

  logic               valid_q;
  logic               valid_d;
  xatp_pkg::xatp_in_t data_q;
  logic               take;

  // The stage can take a word when it is empty or is handing its word on.
  assign in_stall_o = valid_q & ~drain_i;
  assign take       = in_valid_i & ~in_stall_o;
  assign valid_d    = take | (valid_q & ~drain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/xatp_parser_core.sv
// ----------------------------------------------------------------------------
// xatp_parser_core
// Record parser state and per-byte decode logic with the key register.
// ----------------------------------------------------------------------------
module xatp_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  xatp_pkg::xatp_flow_t flow_i,
  input  xatp_pkg::xatp_in_t   item_i,
  output logic                res_valid_o,
  output xatp_pkg::xatp_out_t  res_o
);

  typedef enum logic [5:0] {
    PH_FLAG = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_NAME = 6'b000100,
    PH_TAIL = 6'b001000,
    PH_END  = 6'b010000,
    PH_HALT = 6'b100000
  } phase_e;

  logic [7:0]  key_q;
  phase_e      phase_q, phase_d, phase_c;
  logic [7:0]  bytes_left_q, bytes_left_d, bytes_left_c;
  logic [31:0] size_q, size_d, size_c;
  logic [3:0]  count_q, count_d, count_c;
  logic [31:0] run_pos_q, run_pos_d, run_pos_c;
  logic [31:0] offset_q, offset_d, offset_c;
  logic [15:0] entries_q, entries_d, entries_c;
  logic [7:0]  b;
  logic [31:0] offset_inc;
  logic        fire;

  assign fire       = flow_i.valid & flow_i.drain;
  assign b          = item_i.raw_byte ^ key_q;

  // A restart word clears the parser before its own byte is decoded.
  always_comb begin
    if (item_i.restart) begin
      phase_c      = PH_FLAG;
      bytes_left_c = '0;
      size_c       = '0;
      count_c      = '0;
      run_pos_c    = '0;
      offset_c     = xatp_pkg::HEADER_BYTES;
      entries_c    = '0;
    end else begin
      phase_c      = phase_q;
      bytes_left_c = bytes_left_q;
      size_c       = size_q;
      count_c      = count_q;
      run_pos_c    = run_pos_q;
      offset_c     = offset_q;
      entries_c    = entries_q;
    end
  end

  assign offset_inc = offset_c + 32'd1;

  always_comb begin
    phase_d      = phase_c;
    bytes_left_d = bytes_left_c;
    size_d       = size_c;
    count_d      = count_c;
    run_pos_d    = run_pos_c;
    offset_d     = offset_inc;
    entries_d    = entries_c;
    res_valid_o  = 1'b0;
    res_o        = '0;
    case (phase_c)
      PH_FLAG: begin
        if (b[xatp_pkg::END_FLAG_BIT]) begin
          phase_d             = PH_END;
          res_valid_o         = fire;
          res_o.kind          = xatp_pkg::KIND_END;
          res_o.entry_index   = entries_c;
          res_o.data_position = offset_inc;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          phase_d     = PH_HALT;
          res_valid_o = fire;
          res_o.kind  = xatp_pkg::KIND_ERROR;
        end else begin
          bytes_left_d = b;
          phase_d      = PH_NAME;
        end
      end
      PH_NAME: begin
        bytes_left_d = bytes_left_c - 8'd1;
        if (bytes_left_c == 8'd1) begin
          phase_d = PH_TAIL;
          count_d = '0;
          size_d  = '0;
        end
        res_valid_o     = fire;
        res_o.kind      = xatp_pkg::KIND_NAME;
        res_o.name_char = (b == xatp_pkg::CHAR_BSLASH) ? xatp_pkg::CHAR_SLASH : b;
      end
      PH_TAIL: begin
        // Size bytes arrive little-endian; the time bytes are skipped.
        case (count_c)
          4'd0:    size_d = size_c | {24'd0, b};
          4'd1:    size_d = size_c | {16'd0, b, 8'd0};
          4'd2:    size_d = size_c | {8'd0, b, 16'd0};
          4'd3:    size_d = size_c | {b, 24'd0};
          default: size_d = size_c;
        endcase
        count_d = count_c + 4'd1;
        if (count_c == xatp_pkg::TAIL_LAST) begin
          res_valid_o         = fire;
          res_o.kind          = xatp_pkg::KIND_ENTRY;
          res_o.entry_index   = entries_c;
          res_o.entry_size    = size_c;
          res_o.data_position = run_pos_c;
          run_pos_d           = run_pos_c + size_c;
          if (entries_c != xatp_pkg::INDEX_MAX) begin
            entries_d = entries_c + 16'd1;
          end
          count_d = '0;
          size_d  = '0;
          phase_d = PH_FLAG;
        end
      end
      default: begin
        // Table end or halted: the byte is dropped and the offset holds.
        offset_d = offset_c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= xatp_pkg::KEY_RESET;
      phase_q      <= PH_FLAG;
      bytes_left_q <= '0;
      size_q       <= '0;
      count_q      <= '0;
      run_pos_q    <= '0;
      offset_q     <= xatp_pkg::HEADER_BYTES;
      entries_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        size_q       <= size_d;
        count_q      <= count_d;
        run_pos_q    <= run_pos_d;
        offset_q     <= offset_d;
        entries_q    <= entries_d;
      end
    end
  end

  // A halted parser stays silent until a restart word arrives.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && phase_q == PH_HALT && !item_i.restart) |-> !res_valid_o)
    else $error("result produced while halted");

  // An error result always leaves the parser halted.
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == xatp_pkg::KIND_ERROR) |=> phase_q == PH_HALT)
    else $error("error result without halt");

  // The entry count never goes backwards without a restart.
  a_entries_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !item_i.restart) |=> entries_q >= $past(entries_q))
    else $error("entry count decreased");

  // The data offset does not move once the table end has been seen.
  a_offset_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && phase_q == PH_END && !item_i.restart) |=> $stable(offset_q))
    else $error("offset moved after table end");

endmodule

// File: hw/rtl/xatp_output_stage.sv
// ----------------------------------------------------------------------------
// xatp_output_stage
// Result register that holds one output word until it is taken.
// ----------------------------------------------------------------------------
module xatp_output_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                res_valid_i,
  input  xatp_pkg::xatp_out_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xatp_pkg::xatp_out_t out_data_o
);

  logic                valid_q;
  logic                valid_d;
  xatp_pkg::xatp_out_t data_q;

  // The register is free when empty or when its word leaves at this edge.
  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i ? res_valid_i : (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hw/rtl/xor_archive_table_parser_unit.sv
// ----------------------------------------------------------------------------
// xor_archive_table_parser_unit
// Decodes an XOR-obscured archive entry table one byte per word.
// ----------------------------------------------------------------------------
// Path: the input stage registers each byte and the output register holds
//   its result. Throughput: one byte per cycle while the output side does
//   not stall, a rate set by the same-cycle state update of the parser core.
// Reset: asynchronous, active low; the key returns to 0xF7, the parser waits
//   for a flag byte with the data offset at 8, and both stages are emptied.
// ----------------------------------------------------------------------------
module xor_archive_table_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xatp_pkg::xatp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xatp_pkg::xatp_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  // The pipe has two registers. The input stage captures the raw byte and
  // its restart flag. The parser core decodes the registered byte against
  // its record state and updates that state in the same cycle, so the next
  // byte can follow immediately. Any result goes to the output register.
  xatp_pkg::xatp_flow_t flow;
  xatp_pkg::xatp_in_t   item;
  xatp_pkg::xatp_out_t  res;
  logic                 res_valid;
  logic                 out_free;
  logic                 s1_valid;

  // A byte leaves the input stage only when the output register can take
  // whatever result it produces; bytes that make no result drain the same
  // way, which keeps the state update tied to one condition.
  assign flow.valid = s1_valid;
  assign flow.drain = s1_valid & out_free;

  xatp_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .drain_i    (flow.drain),
    .valid_o    (s1_valid),
    .data_o     (item)
  );

  // The core holds the key register; the user must write it only while the
  // pipe is idle, so no word sees a key change midway. The core does not enforce it.
  xatp_parser_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .flow_i      (flow),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The output register lets a new byte be accepted while a finished
  // result still waits for the downstream side.
  xatp_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (flow.drain),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
